/* rtl/assert_macros.svh */
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/irbm_pkg.sv */
`default_nettype none

package irbm_pkg;

	localparam int BYTE_W     = 8;
	localparam int TICK_W     = 16;
	localparam int POLL_W     = 8;
	localparam int BIT_W      = 4;
	localparam int STAGE_W    = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'b1;

	localparam logic [POLL_W-1:0] ACK_POLL_RESET    = 8'd200;
	localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd1;

	localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

	// which byte of the transfer is in flight
	localparam logic [STAGE_W-1:0] STAGE_DEV  = 2'd0;
	localparam logic [STAGE_W-1:0] STAGE_REG  = 2'd1;
	localparam logic [STAGE_W-1:0] STAGE_DATA = 2'd2;
	localparam logic [STAGE_W-1:0] STAGE_READ = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic              op;
		logic              start_req;
		logic [BYTE_W-1:0] dev_addr;
		logic [BYTE_W-1:0] reg_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              sda_in;
	} in_item_t;

	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] dev_addr;
		logic [BYTE_W-1:0] reg_addr;
		logic [BYTE_W-1:0] wr_data;
	} request_t;

endpackage

`default_nettype wire

/* rtl/irbm_in_if.sv */
`default_nettype none

interface irbm_in_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic                        start_req;
	logic [irbm_pkg::BYTE_W-1:0] dev_addr;
	logic [irbm_pkg::BYTE_W-1:0] reg_addr;
	logic [irbm_pkg::BYTE_W-1:0] wr_data;
	logic                        sda_in;

	modport source (output valid, op, start_req, dev_addr, reg_addr, wr_data, sda_in,
		input ready);
	modport sink (input valid, op, start_req, dev_addr, reg_addr, wr_data, sda_in,
		output ready);
endinterface

`default_nettype wire

/* rtl/irbm_out_if.sv */
`default_nettype none

interface irbm_out_if;
	logic                        valid;
	logic                        ready;
	logic                        scl_level;
	logic                        sda_pull_low;
	logic                        busy_res;
	logic                        done_res;
	logic [irbm_pkg::BYTE_W-1:0] read_byte;
	logic                        ack_error;

	modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
		ack_error, input ready);
	modport sink (input valid, scl_level, sda_pull_low, busy_res, done_res, read_byte,
		ack_error, output ready);
endinterface

`default_nettype wire

/* rtl/irbm_cfg_if.sv */
`default_nettype none

interface irbm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [irbm_pkg::CFG_IDX_W-1:0]  index;
	logic [irbm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/i2c_register_byte_master_top.sv */
// channel   dir  payload
// in_ch     in   op, start_req, dev_addr, reg_addr, wr_data, sda_in
// out_ch    out  scl_level, sda_pull_low, busy_res, done_res, read_byte, ack_error
// cfg_ch    in   index (0 ack_poll_limit, 1 phase_ticks), data
//
// each tick item gives one result item on its way through the input register,
// then the sequencer step into the result register
// one tick item is taken per cycle while the result is not stalled; the sequencer state is the only loop
// arst_n clears the sequencer to idle and loads the register reset values
// a stalled result holds the input register, which then holds off in_ch
`default_nettype none
`include "assert_macros.svh"

module i2c_register_byte_master_top (
	input  wire logic    clk,
	input  wire logic    arst_n,
	irbm_in_if.sink      in_ch,
	irbm_out_if.source   out_ch,
	irbm_cfg_if.sink     cfg_ch
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST1  = 5'd1,
		PH_ST2  = 5'd2,
		PH_ST3  = 5'd3,
		PH_WL   = 5'd4,
		PH_WH   = 5'd5,
		PH_AL   = 5'd6,
		PH_AH   = 5'd7,
		PH_AK   = 5'd8,
		PH_RS0  = 5'd9,
		PH_RL   = 5'd10,
		PH_RH   = 5'd11,
		PH_NL   = 5'd12,
		PH_NH   = 5'd13,
		PH_SP0  = 5'd14,
		PH_SP1  = 5'd15,
		PH_SP2  = 5'd16
	} phase_t;

	// configuration
	logic [irbm_pkg::POLL_W-1:0] poll_limit_q;
	logic [irbm_pkg::TICK_W-1:0] phase_ticks_q;

	// input stage
	irbm_pkg::in_item_t item_s1;
	logic               item_valid_s1;

	// sequencer state
	phase_t                       phase_q, phase_n;
	logic [irbm_pkg::TICK_W-1:0]  tick_q, tick_n;
	logic [irbm_pkg::BIT_W-1:0]   bit_q, bit_n;
	logic [irbm_pkg::BYTE_W-1:0]  shift_q, shift_n;
	logic [irbm_pkg::POLL_W-1:0]  poll_q, poll_n;
	logic [irbm_pkg::STAGE_W-1:0] stage_q, stage_n;
	irbm_pkg::request_t           req_q, req_n;
	logic [irbm_pkg::BYTE_W-1:0]  rx_q, rx_n;
	logic                         err_q, err_n;
	logic                         done_n;
	logic                         scl_n, pull_n;

	// result register
	logic                        out_valid_q;
	logic                        scl_q, pull_q, busy_q, done_q, err_out_q;
	logic [irbm_pkg::BYTE_W-1:0] rx_out_q;

	logic                         advance;
	logic [irbm_pkg::TICK_W:0]    tick_inc;
	logic                         elapsed;
	logic [irbm_pkg::TICK_W-1:0]  tick_adv;
	logic [irbm_pkg::BIT_W-1:0]   bit_inc;

	assign advance      = item_valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !item_valid_s1 || advance;
	assign cfg_ch.ready = 1'b1;

	assign tick_inc = {1'b0, tick_q} + {{irbm_pkg::TICK_W{1'b0}}, 1'b1};
	assign elapsed  = tick_inc >= {1'b0, phase_ticks_q};
	assign tick_adv = elapsed ? '0 : tick_inc[irbm_pkg::TICK_W-1:0];
	assign bit_inc  = bit_q + {{(irbm_pkg::BIT_W-1){1'b0}}, 1'b1};

	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		poll_n  = poll_q;
		stage_n = stage_q;
		req_n   = req_q;
		rx_n    = rx_q;
		err_n   = err_q;
		done_n  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (item_s1.start_req) begin
					req_n.op       = item_s1.op;
					req_n.dev_addr = item_s1.dev_addr;
					req_n.reg_addr = item_s1.reg_addr;
					req_n.wr_data  = item_s1.wr_data;
					err_n   = 1'b0;
					stage_n = irbm_pkg::STAGE_DEV;
					phase_n = PH_ST1;
					tick_n  = '0;
				end
			end
			PH_ST1: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_ST2;
			end
			PH_ST2: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_ST3;
			end
			PH_ST3: begin
				tick_n = tick_adv;
				if (elapsed) begin
					// write direction on the first device byte, read after repeated start
					shift_n = {req_q.dev_addr[irbm_pkg::BYTE_W-1:1],
						stage_q != irbm_pkg::STAGE_DEV};
					bit_n   = '0;
					phase_n = PH_WL;
				end
			end
			PH_WL: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_WH;
			end
			PH_WH: begin
				tick_n = tick_adv;
				if (elapsed) begin
					bit_n = bit_inc;
					if (bit_inc >= irbm_pkg::BITS_PER_BYTE) begin
						phase_n = PH_AL;
					end else begin
						shift_n = {shift_q[irbm_pkg::BYTE_W-2:0], 1'b0};
						phase_n = PH_WL;
					end
				end
			end
			PH_AL: begin
				tick_n = tick_adv;
				if (elapsed) begin
					poll_n  = '0;
					phase_n = PH_AH;
				end
			end
			PH_AH: begin
				if (!item_s1.sda_in) begin
					phase_n = PH_AK;
					tick_n  = '0;
				end else if (poll_q >= poll_limit_q) begin
					err_n   = 1'b1;
					phase_n = PH_SP0;
					tick_n  = '0;
				end else begin
					poll_n = poll_q + {{(irbm_pkg::POLL_W-1){1'b0}}, 1'b1};
				end
			end
			PH_AK: begin
				tick_n = tick_adv;
				if (elapsed) begin
					case (stage_q)
						irbm_pkg::STAGE_DEV: begin
							stage_n = irbm_pkg::STAGE_REG;
							shift_n = req_q.reg_addr;
							bit_n   = '0;
							phase_n = PH_WL;
						end
						irbm_pkg::STAGE_REG: begin
							stage_n = irbm_pkg::STAGE_DATA;
							if (req_q.op == irbm_pkg::OP_WRITE) begin
								shift_n = req_q.wr_data;
								bit_n   = '0;
								phase_n = PH_WL;
							end else begin
								phase_n = PH_RS0;
							end
						end
						default: begin
							if (req_q.op == irbm_pkg::OP_WRITE) begin
								phase_n = PH_SP0;
							end else begin
								stage_n = irbm_pkg::STAGE_READ;
								shift_n = '0;
								bit_n   = '0;
								phase_n = PH_RL;
							end
						end
					endcase
				end
			end
			PH_RS0: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_ST1;
			end
			PH_RL: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_RH;
			end
			PH_RH: begin
				tick_n = tick_adv;
				if (elapsed) begin
					shift_n = {shift_q[irbm_pkg::BYTE_W-2:0], item_s1.sda_in};
					bit_n   = bit_inc;
					if (bit_inc >= irbm_pkg::BITS_PER_BYTE) begin
						rx_n    = {shift_q[irbm_pkg::BYTE_W-2:0], item_s1.sda_in};
						phase_n = PH_NL;
					end else begin
						phase_n = PH_RL;
					end
				end
			end
			PH_NL: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_NH;
			end
			PH_NH: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_SP0;
			end
			PH_SP0: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_SP1;
			end
			PH_SP1: begin
				tick_n = tick_adv;
				if (elapsed) phase_n = PH_SP2;
			end
			PH_SP2: begin
				tick_n = tick_adv;
				if (elapsed) begin
					phase_n = PH_IDLE;
					done_n  = 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				tick_n  = '0;
			end
		endcase
	end

	// line levels for the phase just entered
	always_comb begin
		case (phase_n)
			PH_ST3: begin
				scl_n  = 1'b0;
				pull_n = 1'b1;
			end
			PH_ST2: begin
				scl_n  = 1'b1;
				pull_n = 1'b1;
			end
			PH_WL: begin
				scl_n  = 1'b0;
				pull_n = !shift_n[irbm_pkg::BYTE_W-1];
			end
			PH_WH: begin
				scl_n  = 1'b1;
				pull_n = !shift_n[irbm_pkg::BYTE_W-1];
			end
			PH_AL, PH_AK, PH_RS0, PH_RL, PH_NL: begin
				scl_n  = 1'b0;
				pull_n = 1'b0;
			end
			PH_SP0: begin
				scl_n  = 1'b0;
				pull_n = 1'b1;
			end
			PH_SP1: begin
				scl_n  = 1'b1;
				pull_n = 1'b1;
			end
			default: begin
				scl_n  = 1'b1;
				pull_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q  <= irbm_pkg::ACK_POLL_RESET;
			phase_ticks_q <= irbm_pkg::PHASE_TICKS_RESET;
			item_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
			phase_q       <= PH_IDLE;
			tick_q        <= '0;
			bit_q         <= '0;
			shift_q       <= '0;
			poll_q        <= '0;
			stage_q       <= irbm_pkg::STAGE_DEV;
			req_q         <= '0;
			rx_q          <= '0;
			err_q         <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					irbm_pkg::CFG_ACK_POLL_LIMIT: poll_limit_q <= cfg_ch.data[irbm_pkg::POLL_W-1:0];
					irbm_pkg::CFG_PHASE_TICKS:    phase_ticks_q <= cfg_ch.data;
					default: ;
				endcase
			end
			if (in_ch.ready) item_valid_s1 <= in_ch.valid;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_n;
				tick_q  <= tick_n;
				bit_q   <= bit_n;
				shift_q <= shift_n;
				poll_q  <= poll_n;
				stage_q <= stage_n;
				req_q   <= req_n;
				rx_q    <= rx_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.op        <= in_ch.op;
			item_s1.start_req <= in_ch.start_req;
			item_s1.dev_addr  <= in_ch.dev_addr;
			item_s1.reg_addr  <= in_ch.reg_addr;
			item_s1.wr_data   <= in_ch.wr_data;
			item_s1.sda_in    <= in_ch.sda_in;
		end
		if (advance) begin
			scl_q     <= scl_n;
			pull_q    <= pull_n;
			busy_q    <= phase_n != PH_IDLE;
			done_q    <= done_n;
			rx_out_q  <= rx_n;
			err_out_q <= err_n;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.scl_level    = scl_q;
	assign out_ch.sda_pull_low = pull_q;
	assign out_ch.busy_res     = busy_q;
	assign out_ch.done_res     = done_q;
	assign out_ch.read_byte    = rx_out_q;
	assign out_ch.ack_error    = err_out_q;

	`ASSERT_SAME(a_done_not_busy, out_valid_q && done_q, !busy_q, "done item shows busy")
	`ASSERT_SAME(a_idle_tick_zero, phase_q == PH_IDLE, tick_q == '0, "tick count live in idle")
	`ASSERT_SAME(a_bit_range, 1'b1, bit_q <= irbm_pkg::BITS_PER_BYTE, "bit count past a byte")
	`ASSERT_SAME(a_stall_holds_input, item_valid_s1 && out_valid_q && !out_ch.ready,
		!in_ch.ready, "input taken while result stalled")
	`ASSERT_NEXT(a_accept_fills, in_ch.valid && in_ch.ready, item_valid_s1,
		"accepted item lost from input register")

endmodule

`default_nettype wire
